### src/co12_pkg.sv
// Shared constants, types and transition tables of the Carryover-12 block encoder.
package co12_pkg;

  localparam int MAX_BLOCK   = 32;
  localparam int ADDR_W      = $clog2(MAX_BLOCK);
  localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
  localparam int MAX_WIDTH   = 28;
  localparam int SMALL_LIMIT = 16;
  localparam int WIDTH_W     = 5;
  localparam int GAP_W       = MAX_WIDTH;
  localparam int WORD_W      = 32;
  localparam int BITS_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_GAPS = 2'd1;

  // loader -> packer: a complete block waits in the stores
  typedef struct packed {
    logic               pending;
    logic               bad;
    logic [WIDTH_W-1:0] widest;
    logic [CNT_W-1:0]   count;
  } co12_blk_t;

  // packer -> loader/top
  typedef struct packed {
    logic busy;
    logic done;
  } co12_stat_t;

  // Columns 0..2 of a transition-table row, packed {c2, c1, c0}.
  // tsel = {big tables, 32-bit table}. Empty rows fall back to row 15.
  function automatic logic [3*WIDTH_W-1:0] row_cols(input logic [1:0] tsel,
                                                     input logic [4:0] row);
    logic [3*WIDTH_W-1:0] fb;
    logic [3*WIDTH_W-1:0] r;
    case (tsel)
      2'd0:    fb = {5'd15, 5'd14, 5'd10};
      2'd1:    fb = {5'd15, 5'd10, 5'd8};
      2'd2:    fb = {5'd15, 5'd14, 5'd10};
      default: fb = {5'd16, 5'd15, 5'd10};
    endcase
    case (row) inside
      5'd1, 5'd2: r = {5'd3, 5'd2, 5'd1};
      5'd3:       r = {5'd4, 5'd3, 5'd2};
      5'd4:       r = {5'd5, 5'd4, 5'd3};
      5'd5:       r = {5'd6, 5'd5, 5'd4};
      5'd6:       r = {5'd7, 5'd6, 5'd5};
      5'd7:       r = {5'd8, 5'd7, 5'd6};
      5'd8:       r = tsel[0] ? {5'd10, 5'd9, 5'd7} : {5'd10, 5'd7, 5'd6};
      5'd9: begin
        case (tsel)
          2'd0:    r = {5'd10, 5'd8, 5'd7};
          2'd2:    r = {5'd15, 5'd10, 5'd8};
          default: r = {5'd15, 5'd10, 5'd7};
        endcase
      end
      5'd10:      r = tsel[0] ? {5'd15, 5'd10, 5'd8} : {5'd14, 5'd10, 5'd9};
      5'd14: begin
        case (tsel)
          2'd0:    r = {5'd15, 5'd10, 5'd8};
          2'd2:    r = {5'd16, 5'd15, 5'd10};
          default: r = {5'd15, 5'd10, 5'd7};
        endcase
      end
      5'd16:      r = tsel[0] ? {5'd15, 5'd14, 5'd10} : {5'd15, 5'd10, 5'd7};
      5'd28:      r = tsel[1] ? {5'd16, 5'd10, 5'd6} : fb;
      default:    r = fb;
    endcase
    return r;
  endfunction

endpackage

### src/carryover12_block_encoder_core.sv
// Carryover-12 block encoder: top level with config registers, stores, loader and packer.
// Load: one gap per cycle while no block is pending; the last gap of a block (or the 32nd) hands
//   the block to the packer. Encode: per group a setup step, a prep step, a scan of the values
//   against the columns, a selector step and the packed values, the last two held while a full
//   word cannot be emitted; a too-wide column repeats prep and scan. Flush sends the final word.
// Bad block: the single error transfer is loaded from the error state.
// Reset (rst, synchronous): control cleared, start_row 15, zero mode off; stores not cleared.
module carryover12_block_encoder_core (
  input  logic                               clk,
  input  logic                               rst,
  // gap input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        gap_value,
  input  logic                               block_end,
  // word output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        code_word,
  output logic                               last_word,
  output logic                               gap_error,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [co12_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [co12_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import co12_pkg::*;

  logic [4:0]          start_row;
  logic                zero_gaps;

  co12_blk_t           blk;
  co12_stat_t          stat;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [GAP_W-1:0]    wr_gap;
  logic [WIDTH_W-1:0]  wr_width;
  logic [ADDR_W-1:0]   rd_addr;
  logic [GAP_W-1:0]    rd_gap;
  logic [WIDTH_W-1:0]  rd_width;

  // Config writes must only be issued while idle (the block does not enforce it); always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row <= 5'd15;
      zero_gaps <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_ROW: start_row <= cfg_data[4:0];
        CFG_ZERO_GAPS: zero_gaps <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Loader owns the input transfer and the write side of both stores.
  co12_loader u_loader (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .gap_value (gap_value),
    .block_end (block_end),
    .zero_gaps (zero_gaps),
    .stat      (stat),
    .blk       (blk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_gap    (wr_gap),
    .wr_width  (wr_width)
  );

  // Coded values (minus-one form unless zero mode is on), 28 bits.
  co12_ram #(.WIDTH(GAP_W), .DEPTH(MAX_BLOCK)) u_gap_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_gap),
    .raddr (rd_addr),
    .rdata (rd_gap)
  );

  // Bit widths of the coded values; scanned for the column fit check.
  co12_ram #(.WIDTH(WIDTH_W), .DEPTH(MAX_BLOCK)) u_width_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_width),
    .raddr (rd_addr),
    .rdata (rd_width)
  );

  // Packer reads both stores at one address and drives the output register.
  co12_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .blk       (blk),
    .start_row (start_row),
    .rd_addr   (rd_addr),
    .rd_width  (rd_width),
    .rd_gap    (rd_gap),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_word (code_word),
    .last_word (last_word),
    .gap_error (gap_error),
    .stat      (stat)
  );

  // Error transfer is always a lone, empty, final word.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gap_error) |-> (last_word && code_word == '0))
    else $error("error transfer not a lone final zero word");

  // No gap may be taken while a block is being packed.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> in_stall)
    else $error("input open while packer busy");

  // Finishing a block reopens the input.
  a_done_open: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !in_stall)
    else $error("input still stalled after block done");

endmodule

### src/co12_ram.sv
// Generic single-write, single-read RAM with registered read data.
module co12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/co12_loader.sv
// Gap loader: codes each gap, finds its width, writes the stores, tracks block status.
module co12_loader (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     gap_value,
  input  logic                            block_end,
  input  logic                            zero_gaps,
  input  co12_pkg::co12_stat_t            stat,
  output co12_pkg::co12_blk_t             blk,
  output logic                            wr_en,
  output logic [co12_pkg::ADDR_W-1:0]     wr_addr,
  output logic [co12_pkg::GAP_W-1:0]      wr_gap,
  output logic [co12_pkg::WIDTH_W-1:0]    wr_width
);
  import co12_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [WIDTH_W-1:0] widest;
  logic               bad;
  logic               pending;

  logic [WORD_W-1:0]  coded;
  logic               bad_now;
  logic               bad_next;
  logic               accept;
  logic [WIDTH_W-1:0] wid;
  logic [CNT_W-1:0]   count_inc;

  assign coded     = zero_gaps ? gap_value : gap_value - WORD_W'(1);
  assign bad_now   = (!zero_gaps && gap_value == '0) || (coded[WORD_W-1:MAX_WIDTH] != '0);
  assign bad_next  = bad || bad_now;
  assign accept    = in_valid && !pending;
  assign count_inc = count + CNT_W'(1);

  // bit length of the coded value
  always_comb begin
    wid = '0;
    for (int i = 0; i < GAP_W; i++) begin
      if (coded[i]) wid = WIDTH_W'(i + 1);
    end
  end

  assign wr_en    = accept && !bad_next;
  assign wr_addr  = count[ADDR_W-1:0];
  assign wr_gap   = coded[GAP_W-1:0];
  assign wr_width = wid;
  assign in_stall = pending;

  assign blk.pending = pending;
  assign blk.bad     = bad;
  assign blk.widest  = widest;
  assign blk.count   = count;

  always_ff @(posedge clk) begin
    if (rst || stat.done) begin
      count   <= '0;
      widest  <= '0;
      bad     <= 1'b0;
      pending <= 1'b0;
    end else if (accept) begin
      count <= count_inc;
      bad   <= bad_next;
      if (wr_en && wid > widest) widest <= wid;
      if (block_end || count_inc == CNT_W'(MAX_BLOCK)) pending <= 1'b1;
    end
  end

endmodule

### src/co12_packer.sv
// Word packer: walks the stored block, picks columns by first fit, builds output words.
module co12_packer (
  input  logic                         clk,
  input  logic                         rst,
  input  co12_pkg::co12_blk_t          blk,
  input  logic [4:0]                   start_row,
  output logic [co12_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [co12_pkg::WIDTH_W-1:0] rd_width,
  input  logic [co12_pkg::GAP_W-1:0]   rd_gap,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  code_word,
  output logic                         last_word,
  output logic                         gap_error,
  output co12_pkg::co12_stat_t         stat
);
  import co12_pkg::*;

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_SETUP = 3'd1;
  localparam logic [2:0] P_PREP  = 3'd2;
  localparam logic [2:0] P_SCAN  = 3'd3;
  localparam logic [2:0] P_SEL   = 3'd4;
  localparam logic [2:0] P_VAL   = 3'd5;
  localparam logic [2:0] P_FLUSH = 3'd6;
  localparam logic [2:0] P_ERR   = 3'd7;

  logic [2:0]              state;
  logic [WORD_W-1:0]       accum;
  logic [BITS_W-1:0]       br;
  logic [CNT_W-1:0]        ri;
  logic [4:0]              row;
  logic                    big;
  logic [CNT_W-1:0]        n;
  logic [3:0][WIDTH_W-1:0] cols;
  logic [BITS_W-1:0]       avail;
  logic [3:0]              fits;
  logic [CNT_W-1:0]        k;
  logic [3:0][BITS_W-1:0]  sum;
  logic [3:0][CNT_W-1:0]   cnt;
  logic [2:0]              fail;
  logic [1:0]              sel;
  logic [WIDTH_W-1:0]      size;
  logic [CNT_W-1:0]        elems;

  logic                    out_free;
  logic [CNT_W-1:0]        rem;
  logic [GAP_W-1:0]        pb_val;
  logic [WIDTH_W-1:0]      pb_b;
  logic                    need_emit;
  logic [BITS_W-1:0]       br0;
  logic [BITS_W-1:0]       shamt;
  logic [WORD_W-1:0]       acc_new;
  logic [BITS_W-1:0]       br_new;
  logic [GAP_W-1:0]        mask;
  logic [3:0]              fits_now;
  logic [3:0]              inc;
  logic                    adv;
  logic                    load_out;
  logic [WORD_W-1:0]       load_word;
  logic                    load_last;
  logic                    load_err;

  assign out_free = !out_valid || !out_stall;
  assign rem      = n - ri;

  // bit appender
  always_comb begin
    if (state == P_SEL) begin
      pb_val = GAP_W'(sel);
      pb_b   = WIDTH_W'(2);
    end else begin
      pb_val = rd_gap;
      pb_b   = size;
    end
    need_emit = br < BITS_W'(pb_b);
    br0       = need_emit ? BITS_W'(WORD_W) : br;
    shamt     = BITS_W'(WORD_W) - br0;
    mask      = (GAP_W'(1) << pb_b) - GAP_W'(1);
    acc_new   = (need_emit ? '0 : accum) | (WORD_W'(pb_val & mask) << shamt[4:0]);
    br_new    = br0 - BITS_W'(pb_b);
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      fits_now[j] = BITS_W'(cols[j]) <= avail;
      inc[j] = fits[j] && (k < rem) &&
               ((7'(sum[j]) + 7'(cols[j])) <= 7'(avail));
    end
  end

  assign adv = !need_emit || out_free;

  always_comb begin
    unique case (state)
      P_SCAN:  rd_addr = ADDR_W'(ri + k + CNT_W'(1));
      P_VAL:   rd_addr = adv ? ADDR_W'(ri + CNT_W'(1)) : ri[ADDR_W-1:0];
      default: rd_addr = ri[ADDR_W-1:0];
    endcase
  end

  // output register loading
  always_comb begin
    load_out  = 1'b0;
    load_word = accum;
    load_last = 1'b0;
    load_err  = 1'b0;
    unique case (state)
      P_SEL, P_VAL: load_out = need_emit && out_free;
      P_FLUSH: begin
        load_out  = out_free;
        load_last = 1'b1;
      end
      P_ERR: begin
        load_out  = out_free;
        load_word = '0;
        load_last = 1'b1;
        load_err  = 1'b1;
      end
      default: load_out = 1'b0;
    endcase
  end

  assign stat.busy = state != P_IDLE;
  assign stat.done = (state == P_FLUSH || state == P_ERR) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      code_word <= load_word;
      last_word <= load_last;
      gap_error <= load_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (blk.pending) begin
            if (blk.bad) begin
              state <= P_ERR;
            end else begin
              big   <= blk.widest > WIDTH_W'(SMALL_LIMIT);
              accum <= WORD_W'(blk.widest > WIDTH_W'(SMALL_LIMIT));
              br    <= BITS_W'(WORD_W - 1);
              ri    <= '0;
              row   <= start_row;
              n     <= blk.count;
              state <= P_SETUP;
            end
          end
        end
        P_SETUP: begin
          if (ri == n) begin
            state <= P_FLUSH;
          end else begin
            avail <= (br < BITS_W'(2)) ? BITS_W'(WORD_W - 2) : br - BITS_W'(2);
            {cols[2], cols[1], cols[0]} <= row_cols({big, !(br < BITS_W'(2))}, row);
            cols[3] <= big ? WIDTH_W'(MAX_WIDTH) : WIDTH_W'(SMALL_LIMIT);
            state <= P_PREP;
          end
        end
        P_PREP: begin
          if (!fits_now[0]) begin
            avail <= BITS_W'(WORD_W);
          end else begin
            fits  <= fits_now;
            k     <= '0;
            sum   <= '0;
            cnt   <= '0;
            fail  <= '0;
            state <= P_SCAN;
          end
        end
        P_SCAN: begin
          if (inc != '0) begin
            for (int j = 0; j < 4; j++) begin
              if (inc[j]) begin
                sum[j] <= sum[j] + BITS_W'(cols[j]);
                cnt[j] <= cnt[j] + CNT_W'(1);
              end
            end
            for (int j = 0; j < 3; j++) begin
              if (inc[j] && rd_width > cols[j]) fail[j] <= 1'b1;
            end
            k <= k + CNT_W'(1);
          end else if (fits[0] && !fail[0]) begin
            sel <= 2'd0; size <= cols[0]; elems <= cnt[0]; state <= P_SEL;
          end else if (fits[1] && !fail[1]) begin
            sel <= 2'd1; size <= cols[1]; elems <= cnt[1]; state <= P_SEL;
          end else if (fits[2] && !fail[2]) begin
            sel <= 2'd2; size <= cols[2]; elems <= cnt[2]; state <= P_SEL;
          end else if (fits[3]) begin
            sel <= 2'd3; size <= cols[3]; elems <= cnt[3]; state <= P_SEL;
          end else begin
            // a column did not fit: retry against a fresh word
            avail <= BITS_W'(WORD_W);
            state <= P_PREP;
          end
        end
        P_SEL: begin
          if (adv) begin
            accum <= acc_new;
            br    <= br_new;
            k     <= '0;
            state <= P_VAL;
          end
        end
        P_VAL: begin
          if (adv) begin
            accum <= acc_new;
            br    <= br_new;
            ri    <= ri + CNT_W'(1);
            k     <= k + CNT_W'(1);
            if (k + CNT_W'(1) == elems) begin
              row   <= size;
              state <= P_SETUP;
            end
          end
        end
        P_FLUSH: begin
          if (out_free) state <= P_IDLE;
        end
        P_ERR: begin
          if (out_free) state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/carryover12_block_encoder_core_tb.sv
// Self-checking testbench for the Carryover-12 block encoder core.
module carryover12_block_encoder_core_tb;
  import co12_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 250;

  typedef struct {
    logic [31:0] word;
    logic        lst;
    logic        err;
  } word_rec_t;

  typedef enum int { ROW_GAP, ROW_CFG } row_kind_t;

  // one line of the directed stimulus; chk marks a hand-written expectation
  typedef struct {
    row_kind_t   kind;
    logic [31:0] a;     // gap, or register index
    logic [31:0] b;     // block_end, or register data
    bit          chk;
    logic [31:0] e_word;
    logic        e_last;
    logic        e_err;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] gap_value = '0;
  logic        block_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] code_word;
  logic        last_word;
  logic        gap_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  carryover12_block_encoder_core uut (.*);

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder model: own copy of config and block state
  // ---------------------------------------------------------------------------
  int unsigned low_cols [8][3] = '{'{0,0,0}, '{1,2,3}, '{1,2,3}, '{2,3,4},
                                   '{3,4,5}, '{4,5,6}, '{5,6,7}, '{6,7,8}};
  // rows 8,9,10,14,15,16,28; first index = {big tables, 32-bit table}
  int unsigned high_cols [4][7][3] = '{
    '{'{6,7,10}, '{7,8,10},  '{9,10,14}, '{8,10,15},  '{10,14,15}, '{7,10,15},  '{0,0,0}},
    '{'{7,9,10}, '{7,10,15}, '{8,10,15}, '{7,10,15},  '{8,10,15},  '{10,14,15}, '{0,0,0}},
    '{'{6,7,10}, '{8,10,15}, '{9,10,14}, '{10,15,16}, '{10,14,15}, '{7,10,15},  '{6,10,16}},
    '{'{7,9,10}, '{7,10,15}, '{8,10,15}, '{7,10,15},  '{10,15,16}, '{10,14,15}, '{6,10,16}}};

  logic [4:0]  m_start_row = 5'd15;
  logic        m_zero_mode = 1'b0;
  logic [27:0] m_gaps [MAX_BLOCK];
  int unsigned m_widths [MAX_BLOCK];
  int unsigned m_count = 0;
  int unsigned m_widest = 0;
  bit          m_bad = 0;
  logic [31:0] m_acc;
  int unsigned m_left;
  bit          m_big;
  int unsigned m_cols [4];
  logic [31:0] m_words [$];

  word_rec_t   expected_words [$];
  int unsigned fails = 0;
  int unsigned blocks_done = 0;
  int unsigned words_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned gaps_sent = 0;

  task automatic flush_word();
    m_words.push_back(m_acc);
    m_acc  = '0;
    m_left = 32;
  endtask

  task automatic put_field(logic [31:0] val, int unsigned nb);
    logic [63:0] f;
    if (m_left < nb) flush_word();
    f = {32'b0, val} & ((64'd1 << nb) - 64'd1);
    m_acc = m_acc | 32'(f << (32 - m_left));
    m_left = m_left - nb;
  endtask

  task automatic load_cols(int unsigned tsel, int unsigned row);
    int slot;
    int unsigned c [3];
    c = low_cols[0];
    if (row < 8) c = low_cols[row];
    else begin
      case (row)
        8: slot = 0;  9: slot = 1;  10: slot = 2;  14: slot = 3;
        15: slot = 4; 16: slot = 5; 28: slot = 6;  default: slot = -1;
      endcase
      if (slot >= 0) c = high_cols[tsel][slot];
    end
    if (c[0] == 0) c = high_cols[tsel][4];   // empty row: fall back to row 15
    for (int i = 0; i < 3; i++) m_cols[i] = c[i];
    m_cols[3] = m_big ? MAX_WIDTH : SMALL_LIMIT;
  endtask

  task automatic pack_block();
    int unsigned idx, avail, tsel, j, k, sz, elems, row;
    word_rec_t r;
    m_words.delete();
    m_acc  = '0;
    m_left = 32;
    idx    = 0;
    row    = m_start_row;
    m_big  = m_widest > SMALL_LIMIT;
    put_field(m_big, 1);
    while (idx < m_count) begin
      avail = m_left;
      if (avail < 2) begin
        avail = 30; tsel = 0;
      end else begin
        avail = avail - 2; tsel = 1;
      end
      load_cols((m_big ? 2 : 0) + tsel, row);
      j = 0; sz = m_cols[0]; elems = 1;
      // greedy first fit over the four columns
      while (j < 4) begin
        sz = m_cols[j];
        if (sz > avail) begin
          avail = 32; j = 0;
          continue;
        end
        elems = avail / sz;
        if (elems > m_count - idx) elems = m_count - idx;
        if (j == 3) break;
        for (k = 0; k < elems; k++) if (m_widths[idx + k] > sz) break;
        if (k == elems) break;
        j++;
      end
      put_field(j, 2);
      for (k = 0; k < elems; k++) begin
        put_field(m_gaps[idx], sz);
        idx++;
      end
      row = sz & 31;
    end
    if (m_left < 32) flush_word();
    foreach (m_words[i]) begin
      r = '{m_words[i], (i == m_words.size() - 1), 1'b0};
      expected_words.push_back(r);
    end
  endtask

  // model of one accepted gap transfer
  task automatic take_gap(logic [31:0] g, logic e);
    logic [31:0] v;
    int unsigned w;
    if (m_zero_mode) v = g;
    else begin
      v = g - 1;
      if (g == 0) m_bad = 1;
    end
    if (v >= 32'h1000_0000) m_bad = 1;
    if (!m_bad && m_count < MAX_BLOCK) begin
      w = 0;
      for (int i = 0; i < 32; i++) if (v[i]) w = i + 1;
      m_gaps[m_count]   = v[27:0];
      m_widths[m_count] = w;
      if (w > m_widest) m_widest = w;
    end
    if (m_count < MAX_BLOCK) m_count++;
    if (!e && m_count < MAX_BLOCK) return;
    if (m_bad) expected_words.push_back('{32'd0, 1'b1, 1'b1});
    else pack_block();
    blocks_done++;
    m_count = 0; m_widest = 0; m_bad = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers (change on falling edge, handshake seen at rising edge)
  // ---------------------------------------------------------------------------
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  bit          hold_req = 0;
  int unsigned hold_left = 0;

  task automatic send_gap(logic [31:0] g, logic e);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    gap_value = g;
    block_end = e;
    do @(posedge clk); while (in_stall);
    take_gap(g, e);
    gaps_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_words();
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // registers are only touched with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    drain_words();
    repeat (40) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_START_ROW) m_start_row = d;
    else if (idx == CFG_ZERO_GAPS) m_zero_mode = d[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver stall: random, or a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_rec_t x;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word transfer: code_word %h", code_word);
        fails++;
      end else begin
        x = expected_words.pop_front();
        if (code_word !== x.word) begin
          $error("code_word: expected %h, got %h", x.word, code_word);
          fails++;
        end
        if (last_word !== x.lst) begin
          $error("last_word: expected %0d, got %0d", x.lst, last_word);
          fails++;
        end
        if (gap_error !== x.err) begin
          $error("gap_error: expected %0d, got %0d", x.err, gap_error);
          fails++;
        end
        if (x.err) errors_seen++;
        words_seen++;
      end
    end
  end

  // run limit
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------
  // a coded value of random width, turned back into a gap
  function automatic logic [31:0] rand_gap(bit zmode);
    int unsigned w;
    logic [31:0] v;
    w = $urandom_range(28);
    v = (w == 0) ? 32'd0 : (({$urandom} & ((32'd1 << w) - 1)) | (32'd1 << (w - 1)));
    if ($urandom_range(99) < 3) begin
      // bad gap: zero (all ones in zero mode), or wider than 28 bits
      return $urandom_range(1) ? (zmode ? 32'hFFFF_FFFF : 32'd0)
                               : ($urandom | 32'h2000_0000);
    end
    return zmode ? v : v + 1;
  endfunction

  task automatic rand_block(int unsigned len, bit small_vals);
    logic [31:0] g;
    for (int i = 0; i < len; i++) begin
      g = rand_gap(m_zero_mode);
      if (small_vals && $urandom_range(1)) g = $urandom_range(40);
      if (!m_zero_mode && g == 0 && $urandom_range(3) != 0) g = 1;
      send_gap(g, (i == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t rows [$];
    int unsigned n_rand, len, phase;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part; rows with chk carry a hand-computed result
    rows.push_back('{ROW_GAP, 32'd1,          1, 1, 32'h0000_0000, 1, 0}); // one gap of 1
    rows.push_back('{ROW_GAP, 32'd0,          1, 1, 32'h0000_0000, 1, 1}); // zero gap
    rows.push_back('{ROW_GAP, 32'hFFFF_FFFF,  1, 1, 32'h0000_0000, 1, 1}); // all ones
    rows.push_back('{ROW_GAP, 32'h1000_0000,  1, 1, 32'h7FFF_FFFF, 1, 0}); // 28-bit value
    rows.push_back('{ROW_GAP, 32'h1000_0001,  1, 1, 32'h0000_0000, 1, 1}); // 29-bit value
    rows.push_back('{ROW_GAP, 32'd5,          0, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'h1000_0001,  0, 0, 0, 0, 0});             // bad mid block
    rows.push_back('{ROW_GAP, 32'd3,          1, 1, 32'h0000_0000, 1, 1});
    rows.push_back('{ROW_GAP, 32'h0001_0000,  0, 0, 0, 0, 0});             // width 16
    rows.push_back('{ROW_GAP, 32'h0001_0002,  0, 0, 0, 0, 0});             // width 17: big
    rows.push_back('{ROW_GAP, 32'd2,          0, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'h5555_5555 & 32'h0FFF_FFFF, 1, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'(CFG_START_ROW),  28, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'h0AAA_AAAA,  0, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'd7,          1, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'(CFG_START_ROW),  1, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'd2,          0, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'd300,        1, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'(CFG_ZERO_GAPS),  1, 0, 0, 0, 0});
    rows.push_back('{ROW_GAP, 32'd0,          1, 1, 32'h0000_0000, 1, 0}); // zero allowed
    rows.push_back('{ROW_GAP, 32'hFFFF_FFFF,  1, 1, 32'h0000_0000, 1, 1}); // still too wide
    rows.push_back('{ROW_GAP, 32'h0FFF_FFFF,  1, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'(CFG_ZERO_GAPS),  0, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, 32'(CFG_START_ROW),  15, 0, 0, 0, 0});

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].a[CFG_IDX_W-1:0], rows[i].b[CFG_DATA_W-1:0]);
      end else begin
        send_gap(rows[i].a, rows[i].b[0]);
        if (rows[i].chk) begin
          if (expected_words.size() == 0 ||
              expected_words[$].word !== rows[i].e_word ||
              expected_words[$].lst !== rows[i].e_last ||
              expected_words[$].err !== rows[i].e_err) begin
            $error("directed row %0d: model disagrees with typed result", i);
            fails++;
          end
        end
      end
    end

    // full store: 32 gaps with no block_end close the block, then one more
    for (int i = 0; i < MAX_BLOCK + 1; i++) send_gap($urandom_range(1, 1000), 1'b0);
    send_gap(32'd9, 1'b1);

    // random part in three idling phases
    n_rand = 0;
    for (phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 37 : (phase == 1) ? 69 : 0;
      rcv_idle = (phase == 0) ? 69 : (phase == 1) ? 37 : 0;
      write_reg(CFG_START_ROW, (phase == 0) ? 5'd1 : (phase == 1) ? 5'd28
                                            : 5'($urandom_range(1, 28)));
      write_reg(CFG_ZERO_GAPS, CFG_DATA_W'(phase == 1));
      if (phase == 0) hold_req = 1;   // long receiver hold-off while gaps keep coming
      while (n_rand < RAND_ITEMS * (phase + 1) / 3) begin
        case ($urandom_range(9)) inside
          0:       len = MAX_BLOCK;
          1, 2:    len = $urandom_range(9, 31);
          default: len = $urandom_range(1, 8);
        endcase
        rand_block(len, $urandom_range(3) == 0);
        n_rand += len;
        if ($urandom_range(7) == 0) drain_words();   // sender pauses until all out
        if ($urandom_range(9) == 0)
          write_reg(CFG_START_ROW, 5'($urandom_range(1, 28)));
      end
    end

    drain_words();
    repeat (200) @(posedge clk);
    $display("%0d gaps in %0d blocks; %0d words checked, %0d error transfers",
             gaps_sent, blocks_done, words_seen, errors_seen);
    if (fails == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
